// ----- rtl/ratio_cross_check_match_filter_top_macros.svh -----
// ============================================================================
// Assertion macros for the ratio / cross-check match filter
// Clocked assertion helpers, compiled out when ASSERT_OFF is set.
// ============================================================================
`ifndef RATIO_CROSS_CHECK_MATCH_FILTER_TOP_MACROS_SVH
`define RATIO_CROSS_CHECK_MATCH_FILTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define RCCMF_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
		else $error("rccmf assertion failed");
// condition must never be seen outside reset
`define RCCMF_NEVER(lbl, ck, rstn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) \
		else $error("rccmf forbidden condition seen");
`else
`define RCCMF_ASSERT(lbl, ck, rstn, prop)
`define RCCMF_NEVER(lbl, ck, rstn, cond)
`endif

`endif

// ----- rtl/rccmf_pkg.sv -----
// ============================================================================
// rccmf_pkg
// Shared constants, request codes and store port types of the match filter.
// ============================================================================
`default_nettype none

package rccmf_pkg;

	// store geometry
	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	// field widths
	localparam int IDX_W   = 16;
	localparam int DIST_W  = 16;
	localparam int RATIO_W = 16;
	localparam int NCNT_W  = 2;
	localparam int WORD_W  = 2 * IDX_W;

	// ratio register reset: 0.65 rounded down in Q0.16
	localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd42598;

	// request codes
	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_STORE = 2'd1,
		REQ_TEST  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// store write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} mem_wr_t;

	// store read port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

endpackage

`default_nettype wire

// ----- rtl/ratio_cross_check_match_filter_top.sv -----
// ============================================================================
// ratio_cross_check_match_filter_top
// Ratio test and mutual cross-check filter for two-nearest-neighbour matches.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one request item: clear the
//   store, store a reverse entry, or test a forward entry. in_stall is high
//   while an item is being worked on; the block takes one item at a time.
//   Output channel (out_valid / out_stall) carries a mutual match found for a
//   forward entry; at most one result per forward item.
//   Clear, store and rejected items are captured and then executed. A forward
//   item that passes the ratio test scans the store one pair per cycle through
//   the single store read port until the first match or the last stored pair.
//   A finished result sits in the output register while the next item is
//   accepted; only a second hit waits for the register to drain.
//   Reset clears the count (store is empty), the sequencer and out_valid and
//   restores ratio_q to 0.65. No clearing pass: unwritten entries are never
//   read. A stalled receiver holds the result; payload stays stable.
//   cfg_wr_en / cfg_wr_data write ratio_q (Q0.16). The user must write it only
//   while the block is idle; the block itself does not enforce this.
// ============================================================================
`default_nettype none
`include "ratio_cross_check_match_filter_top_macros.svh"

module ratio_cross_check_match_filter_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_wr_en,
	input  wire logic [rccmf_pkg::RATIO_W-1:0] cfg_wr_data,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     req_type,
	input  wire logic [rccmf_pkg::IDX_W-1:0]   query_index,
	input  wire logic [rccmf_pkg::IDX_W-1:0]   train_index,
	input  wire logic [rccmf_pkg::DIST_W-1:0]  best_distance,
	input  wire logic [rccmf_pkg::DIST_W-1:0]  second_distance,
	input  wire logic [rccmf_pkg::NCNT_W-1:0]  neighbour_count,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [rccmf_pkg::IDX_W-1:0]        out_query_index,
	output logic [rccmf_pkg::IDX_W-1:0]        out_train_index,
	output logic [rccmf_pkg::DIST_W-1:0]       out_distance
);

	localparam int IW = rccmf_pkg::IDX_W;
	localparam logic [rccmf_pkg::CNT_W-1:0] DEPTH_C =
		rccmf_pkg::CNT_W'(rccmf_pkg::STORE_DEPTH);

	rccmf_pkg::state_t state_q, state_d;

	logic [rccmf_pkg::RATIO_W-1:0] ratio_q;
	logic [rccmf_pkg::CNT_W-1:0]   count_q;
	logic [rccmf_pkg::CNT_W-1:0]   idx_q;
	logic                          rd_pend_s1;

	rccmf_pkg::req_t               req_q;
	logic [IW-1:0]                 query_q;
	logic [IW-1:0]                 train_q;
	logic [rccmf_pkg::DIST_W-1:0]  best_q;

	logic                          out_valid_q;
	logic [IW-1:0]                 out_query_q;
	logic [IW-1:0]                 out_train_q;
	logic [rccmf_pkg::DIST_W-1:0]  out_dist_q;

	logic                          accept;
	logic                          pass_s1;
	logic                          hit;
	logic                          scan_done;
	logic                          out_free;
	logic                          load_out;
	logic                          clear_cnt;
	logic [rccmf_pkg::WORD_W-1:0]  rd_data;
	rccmf_pkg::mem_wr_t            mem_wr;
	rccmf_pkg::mem_rd_t            mem_rd;

	// ratio test on the item as it is accepted
	rccmf_ratio u_ratio (
		.clk     (clk),
		.load    (accept),
		.ratio   (ratio_q),
		.best    (best_distance),
		.second  (second_distance),
		.ncount  (neighbour_count),
		.pass_s1 (pass_s1)
	);

	// reverse pair store
	rccmf_store u_store (
		.clk     (clk),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.rd_data (rd_data)
	);

	// compare of the pair read back last cycle
	assign hit = (state_q == rccmf_pkg::ST_SCAN) && rd_pend_s1
		&& (rd_data[rccmf_pkg::WORD_W-1:IW] == train_q)
		&& (rd_data[IW-1:0] == query_q);
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rccmf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = rccmf_pkg::ST_EXEC;
				end
			end
			rccmf_pkg::ST_EXEC: begin
				if (req_q == rccmf_pkg::REQ_TEST && pass_s1 && count_q != '0) begin
					state_d = rccmf_pkg::ST_SCAN;
				end else begin
					state_d = rccmf_pkg::ST_IDLE;
				end
			end
			rccmf_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = rccmf_pkg::ST_EMIT;
				end else if (scan_done) begin
					state_d = rccmf_pkg::ST_IDLE;
				end
			end
			rccmf_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = rccmf_pkg::ST_IDLE;
				end
			end
			default: state_d = rccmf_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall    = 1'b1;
		clear_cnt   = 1'b0;
		load_out    = 1'b0;
		scan_done   = 1'b0;
		mem_wr.en   = 1'b0;
		mem_wr.addr = count_q[rccmf_pkg::ADDR_W-1:0];
		mem_wr.data = {query_q, train_q};
		mem_rd.en   = 1'b0;
		mem_rd.addr = idx_q[rccmf_pkg::ADDR_W-1:0];
		unique case (state_q)
			rccmf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			rccmf_pkg::ST_EXEC: begin
				clear_cnt = (req_q == rccmf_pkg::REQ_CLEAR);
				mem_wr.en = (req_q == rccmf_pkg::REQ_STORE) && pass_s1
					&& (count_q < DEPTH_C);
			end
			rccmf_pkg::ST_SCAN: begin
				mem_rd.en = (idx_q < count_q) && !hit;
				scan_done = !mem_rd.en && rd_pend_s1 && !hit;
			end
			rccmf_pkg::ST_EMIT: begin
				load_out = out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

	assign accept = in_valid && !in_stall;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rccmf_pkg::ST_IDLE;
			ratio_q     <= rccmf_pkg::RATIO_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= mem_rd.en;
			if (cfg_wr_en) begin
				ratio_q <= cfg_wr_data;
			end
			if (clear_cnt) begin
				count_q <= '0;
			end else if (mem_wr.en) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == rccmf_pkg::ST_EXEC) begin
				idx_q <= '0;
			end else if (mem_rd.en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= rccmf_pkg::req_t'(req_type);
			query_q <= query_index;
			train_q <= train_index;
			best_q  <= best_distance;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_query_q <= query_q;
			out_train_q <= train_q;
			out_dist_q  <= best_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_query_index = out_query_q;
	assign out_train_index = out_train_q;
	assign out_distance    = out_dist_q;

	// checks
	`RCCMF_ASSERT(a_count_bound, clk, arst_n, count_q <= DEPTH_C)
	`RCCMF_ASSERT(a_read_in_range, clk, arst_n, mem_rd.en |-> (idx_q < count_q))
	`RCCMF_ASSERT(a_result_from_emit, clk, arst_n,
		$rose(out_valid) |-> $past(state_q == rccmf_pkg::ST_EMIT))
	`RCCMF_NEVER(a_write_in_scan, clk, arst_n,
		mem_wr.en && (state_q != rccmf_pkg::ST_EXEC))

endmodule

`default_nettype wire

// ----- rtl/rccmf_ratio.sv -----
// ============================================================================
// rccmf_ratio
// Ratio test: best * 2^16 <= ratio * second with at least two neighbours.
// Result registered with the item capture.
// ============================================================================
`default_nettype none

module rccmf_ratio (
	input  wire logic                           clk,
	input  wire logic                           load,
	input  wire logic [rccmf_pkg::RATIO_W-1:0] ratio,
	input  wire logic [rccmf_pkg::DIST_W-1:0]  best,
	input  wire logic [rccmf_pkg::DIST_W-1:0]  second,
	input  wire logic [rccmf_pkg::NCNT_W-1:0]  ncount,
	output logic                                pass_s1
);

	localparam int PROD_W = rccmf_pkg::RATIO_W + rccmf_pkg::DIST_W;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] lhs;
	logic              pass;

	// single 16x16 product and compare
	always_comb begin
		prod = PROD_W'(ratio) * PROD_W'(second);
		lhs  = {best, rccmf_pkg::RATIO_W'(0)};
		pass = ncount[1] && (lhs <= prod);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pass_s1 <= pass;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rccmf_store.sv -----
// ============================================================================
// rccmf_store
// Reverse pair store: one write port, one registered read port.
// Word holds query index in the high half, train index in the low half.
// ============================================================================
`default_nettype none

module rccmf_store (
	input  wire logic                          clk,
	input  wire rccmf_pkg::mem_wr_t            wr,
	input  wire rccmf_pkg::mem_rd_t            rd,
	output logic [rccmf_pkg::WORD_W-1:0]       rd_data
);

	logic [rccmf_pkg::WORD_W-1:0] mem [rccmf_pkg::STORE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire
